// ===== hdl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int NUM_ORDERS = 11;
    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int LINK_W     = PAGE_W + 1;
    localparam int ORD_W      = 4;
    localparam int META_W     = ORD_W + 1;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = 13;

    localparam logic [LINK_W-1:0] LINK_NIL      = LINK_W'(NUM_PAGES);
    localparam logic [CNT_W-1:0]  PAGE_COUNT_RST = CNT_W'(4096);
    localparam logic [ORD_W-1:0]  ORD_LIMIT     = ORD_W'(NUM_ORDERS);
    localparam logic [ORD_W-1:0]  ORD_TOP       = ORD_W'(NUM_ORDERS - 1);

    // register index of page_count
    localparam logic REG_PAGE_COUNT = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_SEED  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ORDER = 2'd1,
        ST_NO_MEM    = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR,
        OP_META_RD,
        OP_SCAN_NEXT,
        OP_SCAN_TAKE,
        OP_BUD_RD,
        OP_PULL_RD,
        OP_PULL_LNK,
        OP_PULL_CLR,
        OP_MERGE_UPD,
        OP_SPLIT,
        OP_PUSH_A,
        OP_PUSH_B,
        OP_DONE
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SEED_TST,
        S_SCAN,
        S_PULL_RD,
        S_PULL_LNK,
        S_PULL_CLR,
        S_MERGE_UPD,
        S_SPLIT,
        S_SPLIT_TST,
        S_PUSH_A,
        S_PUSH_B,
        S_FREE_TST,
        S_MERGE_CHK,
        S_MERGE_TST,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op     op;
        t_status status;
        logic    give_blk;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  tgt_bad;
        logic  idx_over;
        logic  head_nil;
        logic  cur_top;
        logic  cur_at_top;
        logic  bud_over;
        logic  cur_gt_tgt;
        logic  half_ok;
        logic  meta_free;
        logic  meta_ord_eq;
        logic  clr_last;
        logic  out_busy;
    } t_stat;

endpackage

// ===== hdl/bpa_req_if.sv =====
// ----------------------------------------------------------------------------
// bpa_req_if
// Request channel: mode, order and page number with valid/ready.
// ----------------------------------------------------------------------------
interface bpa_req_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ORD_W-1:0]  order;
    logic [PAGE_W-1:0] page_num;

    modport source (output valid, output mode, output order, output page_num, input ready);
    modport sink   (input valid, input mode, input order, input page_num, output ready);
endinterface

// ===== hdl/bpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bpa_rsp_if
// Response channel: status and first page of the block with valid/ready.
// ----------------------------------------------------------------------------
interface bpa_rsp_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] first_page;

    modport source (output valid, output status, output first_page, input ready);
    modport sink   (input valid, input status, input first_page, output ready);
endinterface

// ===== hdl/bpa_dpath.sv =====
// ----------------------------------------------------------------------------
// bpa_dpath
// Link memories, block metadata memory, list heads, working registers and
// the response register, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module bpa_dpath import bpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [CNT_W-1:0]  i_limit,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [ORD_W-1:0]  i_order,
    input  logic [PAGE_W-1:0] i_page_num,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [PAGE_W-1:0] o_first_page
);

    // storage
    logic [LINK_W-1:0] m_nxt  [NUM_PAGES];
    logic [LINK_W-1:0] m_prv  [NUM_PAGES];
    logic [META_W-1:0] m_meta [NUM_PAGES];
    logic [LINK_W-1:0] r_head [NUM_ORDERS];

    // working registers
    t_mode             r_mode;
    logic [ORD_W-1:0]  r_tgt;
    logic [ORD_W-1:0]  r_cur;
    logic [PAGE_W-1:0] r_blk;
    logic [PAGE_W-1:0] r_p;
    logic [LINK_W-1:0] r_q;
    logic [LINK_W-1:0] r_h;
    logic [PAGE_W-1:0] r_cnt;
    logic [LINK_W-1:0] r_nx_rd;
    logic [LINK_W-1:0] r_pv_rd;
    logic [META_W-1:0] r_meta_rd;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [PAGE_W-1:0] r_out_blk;

    logic [LINK_W-1:0] head_cur;
    logic [PAGE_W-1:0] bud;
    logic [LINK_W-1:0] half;
    logic [LINK_W-1:0] nx_s;
    logic [LINK_W-1:0] pv_s;
    logic [ORD_W-1:0]  pull_ord;

    logic              nxt_we, prv_we, meta_we, meta_re, link_re;
    logic [PAGE_W-1:0] nxt_wa, prv_wa, meta_a;
    logic [LINK_W-1:0] nxt_wd, prv_wd;
    logic [META_W-1:0] meta_wd;

    // derived values
    assign head_cur = (r_cur < ORD_LIMIT) ? r_head[r_cur] : LINK_NIL;
    assign bud      = r_blk ^ (PAGE_W'(1) << r_cur);
    assign half     = {1'b0, r_blk} + (LINK_W'(1) << (r_cur - 1'b1));
    assign nx_s     = r_nx_rd[PAGE_W] ? LINK_NIL : r_nx_rd;
    assign pv_s     = r_pv_rd[PAGE_W] ? LINK_NIL : r_pv_rd;
    assign pull_ord = (r_mode == MODE_ALLOC) ? r_tgt : r_cur;

    // status toward the controller
    always_comb begin
        o_stat.mode        = r_mode;
        o_stat.tgt_bad     = (r_tgt >= ORD_LIMIT);
        o_stat.idx_over    = (r_q >= i_limit);
        o_stat.head_nil    = head_cur[PAGE_W];
        o_stat.cur_top     = (r_cur >= ORD_LIMIT);
        o_stat.cur_at_top  = (r_cur >= ORD_TOP);
        o_stat.bud_over    = ({1'b0, bud} >= i_limit);
        o_stat.cur_gt_tgt  = (r_cur > r_tgt);
        o_stat.half_ok     = !r_q[PAGE_W];
        o_stat.meta_free   = r_meta_rd[ORD_W];
        o_stat.meta_ord_eq = (r_meta_rd[ORD_W-1:0] == r_cur);
        o_stat.clr_last    = (r_cnt == PAGE_W'(NUM_PAGES - 1));
        o_stat.out_busy    = r_out_valid && !i_out_ready;
    end

    // memory port control
    always_comb begin
        nxt_we  = 1'b0;
        prv_we  = 1'b0;
        meta_we = 1'b0;
        meta_re = 1'b0;
        link_re = 1'b0;
        nxt_wa  = r_q[PAGE_W-1:0];
        prv_wa  = r_q[PAGE_W-1:0];
        meta_a  = r_q[PAGE_W-1:0];
        nxt_wd  = LINK_NIL;
        prv_wd  = LINK_NIL;
        meta_wd = '0;
        case (i_cmd.op)
            OP_CLR: begin
                meta_we = 1'b1;
                meta_a  = r_cnt;
            end
            OP_META_RD: begin
                meta_re = 1'b1;
            end
            OP_BUD_RD: begin
                meta_re = 1'b1;
                meta_a  = bud;
            end
            OP_PULL_RD: begin
                link_re = 1'b1;
            end
            OP_PULL_LNK: begin
                nxt_we = !pv_s[PAGE_W];
                nxt_wa = pv_s[PAGE_W-1:0];
                nxt_wd = nx_s;
                prv_we = !nx_s[PAGE_W];
                prv_wa = nx_s[PAGE_W-1:0];
                prv_wd = pv_s;
            end
            OP_PULL_CLR: begin
                nxt_we  = 1'b1;
                nxt_wa  = r_p;
                prv_we  = 1'b1;
                prv_wa  = r_p;
                meta_we = 1'b1;
                meta_a  = r_p;
                meta_wd = {1'b0, pull_ord};
            end
            OP_PUSH_A: begin
                nxt_we  = 1'b1;
                nxt_wd  = head_cur;
                prv_we  = 1'b1;
                meta_we = 1'b1;
                meta_wd = {1'b1, r_cur};
            end
            OP_PUSH_B: begin
                prv_we = !r_h[PAGE_W];
                prv_wa = r_h[PAGE_W-1:0];
                prv_wd = r_q;
            end
            default: begin
            end
        endcase
    end

    // link memories
    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            m_nxt[nxt_wa] <= nxt_wd;
        end
        if (prv_we) begin
            m_prv[prv_wa] <= prv_wd;
        end
        if (link_re) begin
            r_nx_rd <= m_nxt[r_p];
            r_pv_rd <= m_prv[r_p];
        end
    end

    // metadata memory: free flag and order
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            m_meta[meta_a] <= meta_wd;
        end
        if (meta_re) begin
            r_meta_rd <= m_meta[meta_a];
        end
    end

    // list heads and clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ORDERS; i++) begin
                r_head[i] <= LINK_NIL;
            end
            r_cnt <= '0;
        end else begin
            if (i_cmd.op == OP_CLR) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.op == OP_PULL_LNK && head_cur == {1'b0, r_p}) begin
                r_head[r_cur] <= nx_s;
            end
            if (i_cmd.op == OP_PUSH_A) begin
                r_head[r_cur] <= r_q;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode <= t_mode'(i_mode);
                r_tgt  <= i_order;
                r_cur  <= (t_mode'(i_mode) == MODE_SEED) ? '0 : i_order;
                r_blk  <= i_page_num;
                r_q    <= {1'b0, i_page_num};
            end
            OP_SCAN_NEXT: begin
                r_cur <= r_cur + 1'b1;
            end
            OP_SCAN_TAKE: begin
                r_p   <= head_cur[PAGE_W-1:0];
                r_blk <= head_cur[PAGE_W-1:0];
            end
            OP_BUD_RD: begin
                r_p <= bud;
            end
            OP_MERGE_UPD: begin
                if (r_p < r_blk) begin
                    r_blk <= r_p;
                    r_q   <= {1'b0, r_p};
                end
                r_cur <= r_cur + 1'b1;
            end
            OP_SPLIT: begin
                r_cur <= r_cur - 1'b1;
                r_q   <= half;
            end
            OP_PUSH_A: begin
                r_h <= head_cur;
            end
            default: begin
            end
        endcase
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_DONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DONE) begin
            r_out_status <= i_cmd.status;
            r_out_blk    <= i_cmd.give_blk ? r_blk : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_first_page = r_out_blk;

endmodule

// ===== hdl/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for seed, allocate and free: walks the list scan, the unlink and
// push steps and the split and merge loops, one datapath command a cycle.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state  r_state, n_state;
    t_status r_status, n_status;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_status       = r_status;
        o_in_ready     = 1'b0;
        o_cmd.op       = OP_NONE;
        o_cmd.status   = r_status;
        o_cmd.give_blk = (i_stat.mode == MODE_ALLOC) && (r_status == ST_OK);
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_status = ST_OK;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_stat.mode)
                    MODE_SEED: begin
                        if (i_stat.idx_over) begin
                            n_status = ST_BAD_INDEX;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.op = OP_META_RD;
                            n_state  = S_SEED_TST;
                        end
                    end
                    MODE_ALLOC: begin
                        if (i_stat.tgt_bad) begin
                            n_status = ST_BAD_ORDER;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    MODE_FREE: begin
                        if (i_stat.tgt_bad) begin
                            n_status = ST_BAD_ORDER;
                            n_state  = S_DONE;
                        end else if (i_stat.idx_over) begin
                            n_status = ST_BAD_INDEX;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.op = OP_META_RD;
                            n_state  = S_FREE_TST;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SEED_TST: begin
                n_state = i_stat.meta_free ? S_DONE : S_PUSH_A;
            end
            // look for the smallest non-empty list at or above the asked order
            S_SCAN: begin
                if (i_stat.cur_top) begin
                    n_status = ST_NO_MEM;
                    n_state  = S_DONE;
                end else if (i_stat.head_nil) begin
                    o_cmd.op = OP_SCAN_NEXT;
                end else begin
                    o_cmd.op = OP_SCAN_TAKE;
                    n_state  = S_PULL_RD;
                end
            end
            // unlink a block from its list
            S_PULL_RD: begin
                o_cmd.op = OP_PULL_RD;
                n_state  = S_PULL_LNK;
            end
            S_PULL_LNK: begin
                o_cmd.op = OP_PULL_LNK;
                n_state  = S_PULL_CLR;
            end
            S_PULL_CLR: begin
                o_cmd.op = OP_PULL_CLR;
                n_state  = (i_stat.mode == MODE_ALLOC) ? S_SPLIT : S_MERGE_UPD;
            end
            S_MERGE_UPD: begin
                o_cmd.op = OP_MERGE_UPD;
                n_state  = S_MERGE_CHK;
            end
            // split down to the asked order
            S_SPLIT: begin
                if (i_stat.cur_gt_tgt) begin
                    o_cmd.op = OP_SPLIT;
                    n_state  = S_SPLIT_TST;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SPLIT_TST: begin
                n_state = i_stat.half_ok ? S_PUSH_A : S_SPLIT;
            end
            // push a block on the head of its list
            S_PUSH_A: begin
                o_cmd.op = OP_PUSH_A;
                n_state  = S_PUSH_B;
            end
            S_PUSH_B: begin
                o_cmd.op = OP_PUSH_B;
                n_state  = (i_stat.mode == MODE_ALLOC) ? S_SPLIT : S_DONE;
            end
            S_FREE_TST: begin
                n_state = i_stat.meta_free ? S_DONE : S_MERGE_CHK;
            end
            // merge with a free buddy of equal order
            S_MERGE_CHK: begin
                if (i_stat.cur_at_top || i_stat.bud_over) begin
                    n_state = S_PUSH_A;
                end else begin
                    o_cmd.op = OP_BUD_RD;
                    n_state  = S_MERGE_TST;
                end
            end
            S_MERGE_TST: begin
                if (i_stat.meta_free && i_stat.meta_ord_eq) begin
                    n_state = S_PULL_RD;
                end else begin
                    n_state = S_PUSH_A;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator with per-order doubly linked free lists.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the page metadata memory
// and accepts no request until it ends; page_count may be written
// meanwhile. Requests are handled one at a time by a sequencer that makes
// one access to each single-port memory per cycle. A seed of a page that
// is already free, a rejected request and the unused mode 3 leave the
// lists as they are. An allocate splits down one level at a time; a half
// that lies beyond the store is not pushed. A free merges one level at a
// time while the buddy is free and of equal order; a free of a block
// already free changes nothing. Each list unlink reads the links,
// relinks the neighbours and clears the block; each push writes the
// block and then the back link of the old head. The result sits in an
// output register, so the next request is taken while it waits; a
// request that finishes while that register is still full waits in its
// last step.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpa_req_if.sink     i_req,
    bpa_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] r_page_count;
    logic [CNT_W-1:0] limit;
    t_cmd             cmd;
    t_stat            stat;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= PAGE_COUNT_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_PAGE_COUNT)) begin
            r_page_count <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PAGE_COUNT) ? {{(32-CNT_W){1'b0}}, r_page_count} : '0;

    // usable limit: smaller of page_count and the store size
    assign limit = (r_page_count > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : r_page_count;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpa_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_limit      (limit),
        .i_mode       (i_req.mode),
        .i_order      (i_req.order),
        .i_page_num   (i_req.page_num),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_status     (o_rsp.status),
        .o_first_page (o_rsp.first_page)
    );

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in flight");

    // no request is taken right after reset, at the start of the clearing pass
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("request taken right after reset");

    // only a good allocate carries a block index
    a_blk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.first_page == '0))
        else $error("block index on a failed request");

endmodule

// ===== verif/buddy_page_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_tb
// Drives seed, allocate and free requests into the allocator through the
// request channel and checks every response against a cycle-free model of
// the per-order free lists, or the table for typed rows. A short directed
// table comes first, then random phases, each under its own page count.
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;
    import bpa_pkg::*;

    typedef struct {
        bit          cfg;
        int          cnt;
        logic [1:0]  mode;
        logic [3:0]  ord;
        logic [11:0] idx;
        bit          typed;
        logic [1:0]  st;
        logic [11:0] blk;
    } t_row;

    typedef struct {
        logic [STAT_W-1:0] st;
        logic [PAGE_W-1:0] blk;
    } t_rsp_exp;

    typedef struct {
        int idx;
        int ord;
    } t_block;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bpa_req_if req_if ();
    bpa_rsp_if rsp_if ();

    buddy_page_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // free-list model state
    logic [LINK_W-1:0] free_head [NUM_ORDERS];
    logic [LINK_W-1:0] link_nxt [NUM_PAGES];
    logic [LINK_W-1:0] link_prv [NUM_PAGES];
    logic [ORD_W-1:0]  blk_ord [NUM_PAGES];
    bit                blk_free [NUM_PAGES];
    int                page_cnt;

    t_rsp_exp pending_rsp [$];
    t_block   live_blocks [$];
    bit       failed;
    bit       quiet;
    int       sent;

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #30ms;
        $display("buddy_page_allocator verification failed");
        $finish;
    end

    // push a block at the head of its order list
    function automatic void list_push(int o, int p);
        int h;
        if (o >= NUM_ORDERS || p >= NUM_PAGES) return;
        h = int'(free_head[o]);
        blk_ord[p]  = ORD_W'(o);
        blk_free[p] = 1'b1;
        link_nxt[p] = LINK_W'(h);
        link_prv[p] = LINK_NIL;
        if (h < NUM_PAGES) link_prv[h] = LINK_W'(p);
        free_head[o] = LINK_W'(p);
    endfunction

    // unlink a block from its order list
    function automatic void list_pull(int o, int p);
        int nx;
        int pv;
        if (o >= NUM_ORDERS || p >= NUM_PAGES) return;
        nx = int'(link_nxt[p]);
        pv = int'(link_prv[p]);
        if (nx >= NUM_PAGES) nx = NUM_PAGES;
        if (pv >= NUM_PAGES) pv = NUM_PAGES;
        if (free_head[o] == p) free_head[o] = LINK_W'(nx);
        if (pv < NUM_PAGES) link_nxt[pv] = LINK_W'(nx);
        if (nx < NUM_PAGES) link_prv[nx] = LINK_W'(pv);
        link_nxt[p] = LINK_NIL;
        link_prv[p] = LINK_NIL;
        blk_free[p] = 1'b0;
    endfunction

    // one request against the model
    function automatic void alloc_model(input logic [1:0] m, input logic [3:0] o,
                                        input logic [11:0] idx,
                                        output logic [1:0] st, output logic [11:0] blk);
        int lim;
        int i;
        int b;
        int bud;
        int half;
        int cur;
        lim = (page_cnt < NUM_PAGES) ? page_cnt : NUM_PAGES;
        st  = ST_OK;
        blk = '0;
        if (m == MODE_SEED) begin
            if (idx >= lim) st = ST_BAD_INDEX;
            else if (!blk_free[idx]) list_push(0, int'(idx));
        end else if (m == MODE_ALLOC) begin
            if (o >= NUM_ORDERS) begin
                st = ST_BAD_ORDER;
            end else begin
                i = int'(o);
                while (i < NUM_ORDERS && free_head[i] >= NUM_PAGES) i++;
                if (i >= NUM_ORDERS) begin
                    st = ST_NO_MEM;
                end else begin
                    b = int'(free_head[i]);
                    list_pull(i, b);
                    // split down, upper halves go back on the lists
                    while (i > o) begin
                        i--;
                        half = b + (1 << i);
                        if (half < NUM_PAGES) list_push(i, half);
                    end
                    blk_free[b] = 1'b0;
                    blk_ord[b]  = o;
                    blk = PAGE_W'(b);
                end
            end
        end else if (m == MODE_FREE) begin
            if (o >= NUM_ORDERS) begin
                st = ST_BAD_ORDER;
            end else if (idx >= lim) begin
                st = ST_BAD_INDEX;
            end else if (!blk_free[idx]) begin
                b   = int'(idx);
                cur = int'(o);
                // merge with free buddies of equal order
                while (cur < NUM_ORDERS - 1) begin
                    bud = b ^ (1 << cur);
                    if (bud >= lim) break;
                    if (!blk_free[bud] || blk_ord[bud] != cur) break;
                    list_pull(cur, bud);
                    if (bud < b) b = bud;
                    cur++;
                end
                list_push(cur, b);
            end
        end
    endfunction

    // register write, setup then access, then read back
    task automatic reg_write(int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_PAGE_COUNT);
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (pready !== 1'b1) begin
            $error("pready: expected 1, actual %0b", pready);
            failed = 1'b1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        page_cnt = value & 32'h1FFF;
        @(posedge i_clk);
        if (prdata !== 32'(page_cnt)) begin
            $error("prdata: expected %0d, actual %0d", page_cnt, prdata);
            failed = 1'b1;
        end
    endtask

    // wait until every response is in and the block is idle
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // one request transfer; valid stays high after it for back-to-back items
    task automatic send_req(input logic [1:0] m, input logic [3:0] o,
                            input logic [11:0] idx, input bit typed,
                            input logic [1:0] t_st, input logic [11:0] t_blk,
                            output logic [1:0] st, output logic [11:0] blk);
        int gap;
        t_rsp_exp e;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= m;
        req_if.order    <= o;
        req_if.page_num <= idx;
        do @(posedge i_clk); while (!req_if.ready);
        alloc_model(m, o, idx, st, blk);
        e.st  = typed ? t_st : st;
        e.blk = typed ? t_blk : blk;
        pending_rsp.push_back(e);
        sent++;
    endtask

    task automatic send_noise();
        logic [1:0]  st;
        logic [11:0] blk;
        send_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                 12'($urandom_range(0, 4095)), 1'b0, ST_OK, '0, st, blk);
    endtask

    // response side: random stalls, compare with oldest expectation
    initial begin
        int stall;
        t_rsp_exp e;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            if (pending_rsp.size() == 0) begin
                $error("response transfer with nothing expected");
                failed = 1'b1;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_if.status !== e.st) begin
                    $error("status: expected %0d, actual %0d", e.st, rsp_if.status);
                    failed = 1'b1;
                end
                if (rsp_if.first_page !== e.blk) begin
                    $error("first_page: expected %0d, actual %0d", e.blk,
                           rsp_if.first_page);
                    failed = 1'b1;
                end
            end
        end
    end

    // directed requests
    t_row dir_tab [0:22] = '{
        '{0, 0, MODE_ALLOC, 4'd0,  12'd0,    1, ST_NO_MEM,    12'd0},
        '{0, 0, MODE_ALLOC, 4'd11, 12'd0,    1, ST_BAD_ORDER, 12'd0},
        '{0, 0, MODE_ALLOC, 4'd15, 12'd4095, 1, ST_BAD_ORDER, 12'd0},
        '{0, 0, MODE_FREE,  4'd12, 12'd0,    1, ST_BAD_ORDER, 12'd0},
        '{0, 0, MODE_NONE,  4'd15, 12'd4095, 1, ST_OK,        12'd0},
        '{0, 0, MODE_SEED,  4'd0,  12'd4095, 1, ST_OK,        12'd0},
        '{0, 0, MODE_SEED,  4'd15, 12'd4095, 1, ST_OK,        12'd0},
        '{0, 0, MODE_FREE,  4'd0,  12'd4094, 1, ST_OK,        12'd0},
        '{0, 0, MODE_ALLOC, 4'd0,  12'd0,    0, ST_OK,        12'd0},
        '{0, 0, MODE_FREE,  4'd10, 12'd0,    0, ST_OK,        12'd0},
        '{0, 0, MODE_FREE,  4'd10, 12'd1024, 0, ST_OK,        12'd0},
        '{0, 0, MODE_FREE,  4'd10, 12'd1024, 0, ST_OK,        12'd0},
        '{0, 0, MODE_ALLOC, 4'd10, 12'd0,    0, ST_OK,        12'd0},
        '{0, 0, MODE_ALLOC, 4'd3,  12'd0,    0, ST_OK,        12'd0},
        '{0, 0, MODE_FREE,  4'd2,  12'd5,    0, ST_OK,        12'd0},
        '{0, 0, MODE_FREE,  4'd0,  12'd4095, 0, ST_OK,        12'd0},
        '{1, 0, MODE_NONE,  4'd0,  12'd0,    0, ST_OK,        12'd0},
        '{0, 0, MODE_SEED,  4'd0,  12'd0,    1, ST_BAD_INDEX, 12'd0},
        '{0, 0, MODE_FREE,  4'd0,  12'd0,    1, ST_BAD_INDEX, 12'd0},
        '{0, 0, MODE_FREE,  4'd11, 12'd0,    1, ST_BAD_ORDER, 12'd0},
        '{0, 0, MODE_ALLOC, 4'd0,  12'd0,    0, ST_OK,        12'd0},
        '{1, 4096, MODE_NONE, 4'd0, 12'd0,   0, ST_OK,        12'd0},
        '{0, 0, MODE_SEED,  4'd15, 12'd2048, 0, ST_OK,        12'd0}
    };

    int cnt_choice [0:9] = '{0, 1, 2, 16, 37, 64, 256, 4095, 4096, -1};

    // stimulus
    initial begin
        logic [1:0]  st;
        logic [11:0] blk;
        int          lim;
        int          n;
        int          base;
        int          r;
        int          pc;
        int          perm [$];
        t_block      tb_blk;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        req_if.valid    <= 1'b0;
        req_if.mode     <= MODE_SEED;
        req_if.order    <= '0;
        req_if.page_num <= '0;
        failed   = 1'b0;
        quiet    = 1'b0;
        sent     = 0;
        page_cnt = int'(PAGE_COUNT_RST);
        for (int i = 0; i < NUM_ORDERS; i++) free_head[i] = LINK_NIL;
        for (int i = 0; i < NUM_PAGES; i++) begin
            link_nxt[i] = '0;
            link_prv[i] = '0;
            blk_ord[i]  = '0;
            blk_free[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_tab[k]) begin
            if (dir_tab[k].cfg) begin
                drain();
                reg_write(dir_tab[k].cnt);
            end else begin
                send_req(dir_tab[k].mode, dir_tab[k].ord, dir_tab[k].idx, dir_tab[k].typed,
                         dir_tab[k].st, dir_tab[k].blk, st, blk);
            end
        end

        // random phases, each under its own page count
        while (sent < 1200) begin
            drain();
            pc = cnt_choice[$urandom_range(0, 9)];
            if (pc < 0) pc = $urandom_range(0, 4096);
            reg_write(pc);
            quiet = ($urandom_range(0, 3) == 0);
            lim = (pc < NUM_PAGES) ? pc : NUM_PAGES;
            n = (lim < 64) ? lim : 64;
            base = 64 * $urandom_range(0, (lim - n) / 64);

            // seed a contiguous run of pages in random order
            perm.delete();
            for (int k = 0; k < n; k++) perm.push_back(base + k);
            perm.shuffle();
            foreach (perm[k])
                send_req(MODE_SEED, 4'($urandom_range(0, 15)), PAGE_W'(perm[k]), 1'b0,
                         ST_OK, '0, st, blk);

            // allocs and frees of live blocks, with some noise
            repeat (60) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    tb_blk.ord = (r < 38) ? $urandom_range(0, 3) : $urandom_range(0, 10);
                    send_req(MODE_ALLOC, ORD_W'(tb_blk.ord), 12'($urandom_range(0, 4095)),
                             1'b0, ST_OK, '0, st, blk);
                    if (st == ST_OK) begin
                        tb_blk.idx = int'(blk);
                        live_blocks.push_back(tb_blk);
                    end
                end else if (r < 82 && live_blocks.size() != 0) begin
                    n = $urandom_range(0, live_blocks.size() - 1);
                    tb_blk = live_blocks[n];
                    live_blocks.delete(n);
                    send_req(MODE_FREE, ORD_W'(tb_blk.ord), PAGE_W'(tb_blk.idx), 1'b0,
                             ST_OK, '0, st, blk);
                end else begin
                    send_noise();
                end
            end

            // give back what is left so the lists merge up
            live_blocks.shuffle();
            while (live_blocks.size() != 0) begin
                tb_blk = live_blocks.pop_front();
                send_req(MODE_FREE, ORD_W'(tb_blk.ord), PAGE_W'(tb_blk.idx), 1'b0,
                         ST_OK, '0, st, blk);
            end
        end

        drain();
        if (!failed)
            $display("buddy_page_allocator verification clean");
        else
            $display("buddy_page_allocator verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bpa_pkg.sv
hdl/bpa_req_if.sv
hdl/bpa_rsp_if.sv
hdl/bpa_dpath.sv
hdl/bpa_ctrl.sv
hdl/buddy_page_allocator.sv
verif/buddy_page_allocator_tb.sv
